// ===== design/mouse_stroke_line_interpolator_macros.svh =====
// ---------------------------------------------------------------------------
// Mouse stroke line interpolator: assertion macros
// Shared same-cycle and next-cycle implication property wrappers.
// ---------------------------------------------------------------------------
`ifndef MOUSE_STROKE_LINE_INTERPOLATOR_MACROS_SVH
`define MOUSE_STROKE_LINE_INTERPOLATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define MSLI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msli assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define MSLI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msli assertion failed");

`endif

// ===== design/msli_pkg.sv =====
// ---------------------------------------------------------------------------
// msli_pkg
// Shared types and fixed port widths for the mouse stroke line interpolator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package msli_pkg;

  localparam int PORT_W = 10;
  localparam int MOVE_W = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_SETUP,
    ST_DRAW,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic start;
    logic advance;
  } dda_ctrl_t;

endpackage

// ===== design/msli_dda.sv =====
// ---------------------------------------------------------------------------
// msli_dda
// Shared DDA step unit: per axis, keeps trunc(i*mag/steps) and its remainder
// and advances i by one per step with a single compare and subtract.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module msli_dda #(
  parameter int STEP_W = 6
) (
  input  logic                clk,
  input  msli_pkg::dda_ctrl_t ctrl,
  input  logic [STEP_W-1:0]   mag_c,
  input  logic [STEP_W-1:0]   mag_r,
  input  logic [STEP_W-1:0]   steps,
  output logic [STEP_W-1:0]   off_c,
  output logic [STEP_W-1:0]   off_r,
  output logic                done
);

  logic [STEP_W-1:0] idx;
  logic [STEP_W-1:0] qc;
  logic [STEP_W-1:0] rc;
  logic [STEP_W-1:0] qr;
  logic [STEP_W-1:0] rr;
  logic [STEP_W:0]   sum_c;
  logic [STEP_W:0]   sum_r;
  logic [STEP_W:0]   steps_x;
  logic              wrap_c;
  logic              wrap_r;

  always_comb begin
    steps_x = {1'b0, steps};
    sum_c   = {1'b0, rc} + {1'b0, mag_c};
    sum_r   = {1'b0, rr} + {1'b0, mag_r};
    wrap_c  = sum_c >= steps_x;
    wrap_r  = sum_r >= steps_x;
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      idx <= '0;
      qc  <= '0;
      rc  <= '0;
      qr  <= '0;
      rr  <= '0;
    end else if (ctrl.advance) begin
      idx <= idx + 1'b1;
      if (wrap_c) begin
        rc <= STEP_W'(sum_c - steps_x);
        qc <= qc + 1'b1;
      end else begin
        rc <= sum_c[STEP_W-1:0];
      end
      if (wrap_r) begin
        rr <= STEP_W'(sum_r - steps_x);
        qr <= qr + 1'b1;
      end else begin
        rr <= sum_r[STEP_W-1:0];
      end
    end
  end

  assign off_c = qc;
  assign off_r = qr;
  assign done  = idx == steps;

endmodule

// ===== design/mouse_stroke_line_interpolator.sv =====
// ---------------------------------------------------------------------------
// mouse_stroke_line_interpolator
// Cursor tracking with DDA stroke interpolation between mouse events.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one mouse event per beat: move_x,
// move_y and button_held. Output channel (out_valid/out_ready) gives one
// beat per stroke point, or a single beat with point_valid low when the
// event draws nothing; last_of_run marks the final beat of each event.
// An event goes through its accept, cursor update and line setup, then gives
// one result beat per point, or a single beat for an event without points;
// an event gives up to MAX_MOVE + 1 points. The rate is set by the DDA step
// unit, one point per cycle while the receiver keeps taking beats.
// in_ready is high only while the sequencer is idle; the last result may
// still sit in the output register while the next event is taken.
// A stalled receiver holds the output register and freezes the DDA until
// the beat is taken. Reset (rst, synchronous) puts the cursor at the screen
// center, clears the anchor and the stored point count, and drops out_valid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mouse_stroke_line_interpolator #(
  parameter int SCREEN_COLS    = 1024,
  parameter int SCREEN_ROWS    = 768,
  parameter int POINT_CAPACITY = 8192,
  parameter int MAX_MOVE       = 63
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [msli_pkg::MOVE_W-1:0]  move_x,
  input  logic signed [msli_pkg::MOVE_W-1:0]  move_y,
  input  logic                                button_held,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [msli_pkg::PORT_W-1:0]         cursor_col,
  output logic [msli_pkg::PORT_W-1:0]         cursor_row,
  output logic                                point_valid,
  output logic [msli_pkg::PORT_W-1:0]         point_col,
  output logic [msli_pkg::PORT_W-1:0]         point_row,
  output logic                                last_of_run
);

  `include "mouse_stroke_line_interpolator_macros.svh"

  localparam int PW      = msli_pkg::PORT_W;
  localparam int SCR_MAX = (SCREEN_COLS > SCREEN_ROWS) ? SCREEN_COLS : SCREEN_ROWS;
  localparam int COORD_W = $clog2(SCR_MAX);
  localparam int SUM_W   = COORD_W + 10;
  localparam int STEP_W  = $clog2(MAX_MOVE + 1);
  localparam int CNT_W   = $clog2(POINT_CAPACITY + 1);

  localparam logic signed [SUM_W-1:0] MOVE_HI = SUM_W'(MAX_MOVE);
  localparam logic signed [SUM_W-1:0] MOVE_LO = -SUM_W'(MAX_MOVE);
  localparam logic signed [SUM_W-1:0] COL_HI  = SUM_W'(SCREEN_COLS - 1);
  localparam logic signed [SUM_W-1:0] ROW_HI  = SUM_W'(SCREEN_ROWS - 1);
  localparam logic [COORD_W-1:0]      COL_MID = COORD_W'(SCREEN_COLS / 2);
  localparam logic [COORD_W-1:0]      ROW_MID = COORD_W'(SCREEN_ROWS / 2);
  localparam logic [CNT_W-1:0]        CAP_V   = CNT_W'(POINT_CAPACITY);
  localparam logic [CNT_W-1:0]        CAP_M1  = CNT_W'(POINT_CAPACITY - 1);

  msli_pkg::state_t    state;
  msli_pkg::state_t    state_next;
  msli_pkg::dda_ctrl_t dda_ctrl;

  logic signed [SUM_W-1:0] mx;
  logic signed [SUM_W-1:0] my;
  logic                    btn;
  logic [COORD_W-1:0]      cursor_col_reg;
  logic [COORD_W-1:0]      cursor_row_reg;
  logic [COORD_W-1:0]      anchor_col;
  logic [COORD_W-1:0]      anchor_row;
  logic                    anchor_valid;
  logic [CNT_W-1:0]        points_stored;
  logic [COORD_W-1:0]      org_col;
  logic [COORD_W-1:0]      org_row;
  logic                    neg_c;
  logic                    neg_r;
  logic [STEP_W-1:0]       mag_c;
  logic [STEP_W-1:0]       mag_r;
  logic [STEP_W-1:0]       steps;

  logic signed [SUM_W-1:0] in_x;
  logic signed [SUM_W-1:0] in_y;
  logic signed [SUM_W-1:0] mx_sat;
  logic signed [SUM_W-1:0] my_sat;
  logic signed [SUM_W-1:0] col_sum;
  logic signed [SUM_W-1:0] row_sum;
  logic [COORD_W-1:0]      col_new;
  logic [COORD_W-1:0]      row_new;
  logic signed [COORD_W:0] dc;
  logic signed [COORD_W:0] dr;
  logic [COORD_W-1:0]      abs_c;
  logic [COORD_W-1:0]      abs_r;
  logic [STEP_W-1:0]       ac;
  logic [STEP_W-1:0]       ar;
  logic [STEP_W-1:0]       steps_new;
  logic                    can_draw;
  logic                    line_go;
  logic                    slot_free;
  logic                    load;
  logic                    load_point;
  logic [STEP_W-1:0]       off_c;
  logic [STEP_W-1:0]       off_r;
  logic                    done;
  logic [COORD_W-1:0]      pc;
  logic [COORD_W-1:0]      pr;
  logic                    point_last;

  msli_dda #(
    .STEP_W(STEP_W)
  ) u_dda (
    .clk   (clk),
    .ctrl  (dda_ctrl),
    .mag_c (mag_c),
    .mag_r (mag_r),
    .steps (steps),
    .off_c (off_c),
    .off_r (off_r),
    .done  (done)
  );

  // motion saturation and cursor clamp
  always_comb begin
    in_x = SUM_W'(move_x);
    in_y = SUM_W'(move_y);
    mx_sat = (in_x > MOVE_HI) ? MOVE_HI : ((in_x < MOVE_LO) ? MOVE_LO : in_x);
    my_sat = (in_y > MOVE_HI) ? MOVE_HI : ((in_y < MOVE_LO) ? MOVE_LO : in_y);
    col_sum = $signed({{(SUM_W-COORD_W){1'b0}}, cursor_col_reg}) + mx;
    row_sum = $signed({{(SUM_W-COORD_W){1'b0}}, cursor_row_reg}) - my;
    if (col_sum < 0) begin
      col_new = '0;
    end else if (col_sum > COL_HI) begin
      col_new = COL_HI[COORD_W-1:0];
    end else begin
      col_new = col_sum[COORD_W-1:0];
    end
    if (row_sum < 0) begin
      row_new = '0;
    end else if (row_sum > ROW_HI) begin
      row_new = ROW_HI[COORD_W-1:0];
    end else begin
      row_new = row_sum[COORD_W-1:0];
    end
  end

  // line setup from anchor to new cursor
  always_comb begin
    dc = $signed({1'b0, cursor_col_reg}) - $signed({1'b0, anchor_col});
    dr = $signed({1'b0, cursor_row_reg}) - $signed({1'b0, anchor_row});
    abs_c = dc[COORD_W] ? COORD_W'(-dc) : dc[COORD_W-1:0];
    abs_r = dr[COORD_W] ? COORD_W'(-dr) : dr[COORD_W-1:0];
    ac = STEP_W'(abs_c);
    ar = STEP_W'(abs_r);
    steps_new = (ac > ar) ? ac : ar;
    can_draw = btn && (points_stored < CAP_V);
    line_go = can_draw && anchor_valid && (steps_new != '0);
  end

  always_comb begin
    pc = neg_c ? org_col - COORD_W'(off_c) : org_col + COORD_W'(off_c);
    pr = neg_r ? org_row - COORD_W'(off_r) : org_row + COORD_W'(off_r);
    point_last = done || (points_stored == CAP_M1);
    slot_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msli_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    dda_ctrl.start   = 1'b0;
    dda_ctrl.advance = 1'b0;
    load             = 1'b0;
    load_point       = 1'b0;
    case (state)
      msli_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = msli_pkg::ST_MOVE;
        end
      end
      msli_pkg::ST_MOVE: begin
        state_next = msli_pkg::ST_SETUP;
      end
      msli_pkg::ST_SETUP: begin
        dda_ctrl.start = 1'b1;
        state_next = line_go ? msli_pkg::ST_DRAW : msli_pkg::ST_EMPTY;
      end
      msli_pkg::ST_DRAW: begin
        if (slot_free) begin
          load             = 1'b1;
          load_point       = 1'b1;
          dda_ctrl.advance = 1'b1;
          if (point_last) begin
            state_next = msli_pkg::ST_IDLE;
          end
        end
      end
      msli_pkg::ST_EMPTY: begin
        if (slot_free) begin
          load       = 1'b1;
          state_next = msli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = msli_pkg::ST_IDLE;
      end
    endcase
  end

  // event state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col_reg <= COL_MID;
      cursor_row_reg <= ROW_MID;
      anchor_col     <= '0;
      anchor_row     <= '0;
      anchor_valid   <= 1'b0;
      points_stored  <= '0;
    end else begin
      if (state == msli_pkg::ST_MOVE) begin
        cursor_col_reg <= col_new;
        cursor_row_reg <= row_new;
      end
      if (state == msli_pkg::ST_SETUP) begin
        if (can_draw) begin
          anchor_col   <= cursor_col_reg;
          anchor_row   <= cursor_row_reg;
          anchor_valid <= 1'b1;
        end else begin
          anchor_valid <= 1'b0;
        end
      end
      if (load_point) begin
        points_stored <= points_stored + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mx  <= mx_sat;
      my  <= my_sat;
      btn <= button_held;
    end
    if (state == msli_pkg::ST_SETUP) begin
      org_col <= anchor_col;
      org_row <= anchor_row;
      neg_c   <= dc[COORD_W];
      neg_r   <= dr[COORD_W];
      mag_c   <= ac;
      mag_r   <= ar;
      steps   <= steps_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cursor_col  <= PW'(cursor_col_reg);
      cursor_row  <= PW'(cursor_row_reg);
      point_valid <= load_point;
      point_col   <= load_point ? PW'(pc) : '0;
      point_row   <= load_point ? PW'(pr) : '0;
      last_of_run <= load_point ? point_last : 1'b1;
    end
  end

  `MSLI_ASSERT_NOW(a_empty_beat_clean, out_valid && !point_valid,
                   point_col == '0 && point_row == '0 && last_of_run)
  `MSLI_ASSERT_NOW(a_store_bounded, 1'b1, points_stored <= CAP_V)
  `MSLI_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready && !load)
  `MSLI_ASSERT_NOW(a_draw_has_room, state == msli_pkg::ST_DRAW, points_stored < CAP_V)

endmodule

// ===== dv/mouse_stroke_line_interpolator_checker.sv =====
// ---------------------------------------------------------------------------
// Mouse stroke line interpolator: checker
// Watches both channels, predicts cursor and stroke point beats for every
// accepted event and compares each accepted output beat with the oldest one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mouse_stroke_line_interpolator_checker #(
  parameter int SCREEN_COLS    = 1024,
  parameter int SCREEN_ROWS    = 768,
  parameter int POINT_CAPACITY = 8192,
  parameter int MAX_MOVE       = 63
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [msli_pkg::MOVE_W-1:0] move_x,
  input  logic signed [msli_pkg::MOVE_W-1:0] move_y,
  input  logic                               button_held,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [msli_pkg::PORT_W-1:0]        cursor_col,
  input  logic [msli_pkg::PORT_W-1:0]        cursor_row,
  input  logic                               point_valid,
  input  logic [msli_pkg::PORT_W-1:0]        point_col,
  input  logic [msli_pkg::PORT_W-1:0]        point_row,
  input  logic                               last_of_run,
  output int                                 errors,
  output int                                 pending,
  output int                                 stored_points
);

  typedef struct packed {
    logic [msli_pkg::PORT_W-1:0] ccol;
    logic [msli_pkg::PORT_W-1:0] crow;
    logic                        pvalid;
    logic [msli_pkg::PORT_W-1:0] pcol;
    logic [msli_pkg::PORT_W-1:0] prow;
    logic                        last;
  } stroke_beat_t;

  stroke_beat_t stroke_beats_due[$];

  int cur_col;
  int cur_row;
  int anchor_col;
  int anchor_row;
  bit anchor_set;
  int points_stored;
  int err_count = 0;

  function automatic int limit_move(logic signed [msli_pkg::MOVE_W-1:0] m);
    int v;
    v = m;
    if (v > MAX_MOVE) return MAX_MOVE;
    if (v < -MAX_MOVE) return -MAX_MOVE;
    return v;
  endfunction

  function automatic int clip(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void trace_stroke(logic signed [msli_pkg::MOVE_W-1:0] mx,
                                       logic signed [msli_pkg::MOVE_W-1:0] my, logic btn);
    int dc;
    int dr;
    int steps;
    int i;
    bit done;
    stroke_beat_t b;
    cur_col = clip(cur_col + limit_move(mx), SCREEN_COLS - 1);
    cur_row = clip(cur_row - limit_move(my), SCREEN_ROWS - 1);
    b.ccol = msli_pkg::PORT_W'(cur_col);
    b.crow = msli_pkg::PORT_W'(cur_row);
    steps = 0;
    if (btn && points_stored < POINT_CAPACITY) begin
      if (anchor_set) begin
        dc = cur_col - anchor_col;
        dr = cur_row - anchor_row;
        steps = (dc < 0) ? -dc : dc;
        if (((dr < 0) ? -dr : dr) > steps) steps = (dr < 0) ? -dr : dr;
        if (steps > 0) begin
          for (i = 0; i <= steps; i++) begin
            points_stored++;
            done = (i == steps) || (points_stored >= POINT_CAPACITY);
            b.pvalid = 1'b1;
            // int division truncates toward zero
            b.pcol = msli_pkg::PORT_W'(anchor_col + (i * dc) / steps);
            b.prow = msli_pkg::PORT_W'(anchor_row + (i * dr) / steps);
            b.last = done;
            stroke_beats_due.push_back(b);
            if (done) break;
          end
        end
      end
      anchor_col = cur_col;
      anchor_row = cur_row;
      anchor_set = 1'b1;
    end else begin
      anchor_set = 1'b0;
    end
    if (steps == 0) begin
      b.pvalid = 1'b0;
      b.pcol = '0;
      b.prow = '0;
      b.last = 1'b1;
      stroke_beats_due.push_back(b);
    end
  endfunction

  function automatic void check_beat();
    stroke_beat_t e;
    if (stroke_beats_due.size() == 0) begin
      if (err_count < 10)
        $display("[%0t] output beat with nothing expected: cur=(%0d,%0d) pt=%0b(%0d,%0d)",
                 $time, cursor_col, cursor_row, point_valid, point_col, point_row);
      err_count++;
    end else begin
      e = stroke_beats_due.pop_front();
      if (cursor_col !== e.ccol || cursor_row !== e.crow || point_valid !== e.pvalid ||
          point_col !== e.pcol || point_row !== e.prow || last_of_run !== e.last) begin
        if (err_count < 10) begin
          $display("[%0t] beat mismatch, expected cur=(%0d,%0d) pt=%0b(%0d,%0d) last=%0b",
                   $time, e.ccol, e.crow, e.pvalid, e.pcol, e.prow, e.last);
          $display("[%0t]                  got cur=(%0d,%0d) pt=%0b(%0d,%0d) last=%0b",
                   $time, cursor_col, cursor_row, point_valid, point_col, point_row,
                   last_of_run);
        end
        err_count++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cur_col = SCREEN_COLS / 2;
      cur_row = SCREEN_ROWS / 2;
      anchor_col = 0;
      anchor_row = 0;
      anchor_set = 1'b0;
      points_stored = 0;
      stroke_beats_due.delete();
    end else begin
      if (in_valid && in_ready) trace_stroke(move_x, move_y, button_held);
      if (out_valid && out_ready) check_beat();
    end
    errors <= err_count;
    pending <= stroke_beats_due.size();
    stored_points <= points_stored;
  end

endmodule

// ===== dv/mouse_stroke_line_interpolator_tb.sv =====
// ---------------------------------------------------------------------------
// Mouse stroke line interpolator: testbench top
// Drives directed and random mouse events with random idling on both
// channels, a long output stall, a drain pause and a final store-fill phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mouse_stroke_line_interpolator_tb;

  localparam int SCREEN_COLS    = 1024;
  localparam int SCREEN_ROWS    = 768;
  localparam int POINT_CAPACITY = 8192;
  localparam int MAX_MOVE       = 63;
  localparam int LONG_HOLD      = 400;
  localparam int RANDOM_EVENTS  = 340;
  localparam int MOVE_W         = msli_pkg::MOVE_W;
  localparam int PORT_W         = msli_pkg::PORT_W;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [MOVE_W-1:0] move_x = '0;
  logic signed [MOVE_W-1:0] move_y = '0;
  logic                     button_held = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [PORT_W-1:0]        cursor_col;
  logic [PORT_W-1:0]        cursor_row;
  logic                     point_valid;
  logic [PORT_W-1:0]        point_col;
  logic [PORT_W-1:0]        point_row;
  logic                     last_of_run;

  int mismatches;
  int pending;
  int stored_points;

  logic calm = 1'b0;
  logic hold_req = 1'b0;
  int   tx_gap_odds = 4;

  always #4 clk = ~clk;

  mouse_stroke_line_interpolator #(
    .SCREEN_COLS(SCREEN_COLS), .SCREEN_ROWS(SCREEN_ROWS),
    .POINT_CAPACITY(POINT_CAPACITY), .MAX_MOVE(MAX_MOVE)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .move_x(move_x), .move_y(move_y), .button_held(button_held),
    .out_valid(out_valid), .out_ready(out_ready),
    .cursor_col(cursor_col), .cursor_row(cursor_row),
    .point_valid(point_valid), .point_col(point_col), .point_row(point_row),
    .last_of_run(last_of_run)
  );

  mouse_stroke_line_interpolator_checker #(
    .SCREEN_COLS(SCREEN_COLS), .SCREEN_ROWS(SCREEN_ROWS),
    .POINT_CAPACITY(POINT_CAPACITY), .MAX_MOVE(MAX_MOVE)
  ) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .move_x(move_x), .move_y(move_y), .button_held(button_held),
    .out_valid(out_valid), .out_ready(out_ready),
    .cursor_col(cursor_col), .cursor_row(cursor_row),
    .point_valid(point_valid), .point_col(point_col), .point_row(point_row),
    .last_of_run(last_of_run),
    .errors(mismatches), .pending(pending), .stored_points(stored_points)
  );

  function automatic int any_move();
    return int'($urandom_range(0, 127)) - 64;
  endfunction

  function automatic int toward(int dir);
    if (dir > 0) return int'($urandom_range(40, 63));
    return -int'($urandom_range(40, 64));
  endfunction

  task automatic offer_event(input int mx, input int my, input bit btn);
    if (tx_gap_odds != 0 && $urandom_range(0, tx_gap_odds) == 0) begin
      in_valid <= 1'b0;
      move_x <= MOVE_W'($urandom);
      move_y <= MOVE_W'($urandom);
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    move_x <= MOVE_W'(mx);
    move_y <= MOVE_W'(my);
    button_held <= btn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receiver pacing, with one long hold to back the block up
  initial begin : rx_pacing
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int sent;
    int kind;
    int len;
    int j;
    int sx;
    int sy;
    int k;
    bit flip;
    bit hold_asked;
    bit paused;
    sent = 0;
    hold_asked = 1'b0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: no anchor, zero-length line, extremes, saturation, release
    offer_event(0, 0, 1'b1);
    offer_event(0, 0, 1'b1);
    offer_event(63, 0, 1'b1);
    offer_event(-64, -64, 1'b1);
    offer_event(63, 63, 1'b1);
    offer_event(5, -40, 1'b1);
    offer_event(-17, 3, 1'b1);
    offer_event(1, 1, 1'b1);
    offer_event(0, 0, 1'b0);
    offer_event(-64, 0, 1'b0);
    offer_event(10, 10, 1'b1);
    // drag into the top-left corner, last lines collapse at the edge
    for (j = 0; j < 9; j++) offer_event(-64, 63, 1'b1);
    offer_event(0, -64, 1'b1);
    offer_event(0, 0, 1'b0);

    while (sent < RANDOM_EVENTS) begin
      if (!hold_asked && sent >= 100) begin
        hold_req <= 1'b1;
        hold_asked = 1'b1;
      end
      if (!paused && sent >= 220) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        paused = 1'b1;
      end
      kind = int'($urandom_range(0, 19));
      len = (kind >= 15) ? int'($urandom_range(1, 6)) : int'($urandom_range(3, 16));
      tx_gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 4;
      sx = $urandom_range(0, 1) ? 1 : -1;
      sy = $urandom_range(0, 1) ? 1 : -1;
      for (j = 0; j < len; j++) begin
        if (kind < 7)
          offer_event(any_move(), any_move(), 1'b1);
        else if (kind < 12)
          offer_event(int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4, 1'b1);
        else if (kind < 15)
          offer_event(toward(sx), toward(sy), 1'b1);
        else
          offer_event(any_move(), any_move(), 1'($urandom_range(0, 1)));
        sent++;
      end
    end

    // fill the point store with long strokes, then events against a full store
    calm <= 1'b1;
    tx_gap_odds = 0;
    flip = 1'b1;
    for (k = 0; k < 200 && stored_points < POINT_CAPACITY; k++) begin
      sx = int'($urandom_range(20, 63));
      offer_event(flip ? sx : -sx, int'($urandom_range(0, 8)) - 4, 1'b1);
      flip = !flip;
    end
    for (k = 0; k < 6; k++) offer_event(any_move(), any_move(), k != 3);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/msli_pkg.sv
design/msli_dda.sv
design/mouse_stroke_line_interpolator.sv
dv/mouse_stroke_line_interpolator_checker.sv
dv/mouse_stroke_line_interpolator_tb.sv
